### src/hspd_pkg.sv
// Shared types and constants for the humidity sensor pulse decoder.
// No dependencies; imported by humidity_sensor_pulse_decoder.
package hspd_pkg;

   // Field widths
   localparam int TIME_W  = 16;
   localparam int SCALE_W = 15;
   localparam int BYTE_W  = 8;

   // Configuration register indexes
   localparam logic [7:0] REG_ACK_CENTER  = 8'd0;
   localparam logic [7:0] REG_ONE_CENTER  = 8'd1;
   localparam logic [7:0] REG_ZERO_CENTER = 8'd2;
   localparam logic [7:0] REG_TOLERANCE   = 8'd3;

   // Register reset values
   localparam logic [TIME_W-1:0] ACK_CENTER_RST  = 16'd160;
   localparam logic [TIME_W-1:0] ONE_CENTER_RST  = 16'd120;
   localparam logic [TIME_W-1:0] ZERO_CENTER_RST = 16'd76;
   localparam logic [TIME_W-1:0] TOLERANCE_RST   = 16'd20;

   // Scale factors for the reported readings
   localparam logic [SCALE_W-1:0] SCALE_HUNDRED = 15'd100;
   localparam logic [SCALE_W-1:0] SCALE_TEN     = 15'd10;

   // Highest value of the saturating byte counter
   localparam logic [2:0] BYTE_COUNT_MAX = 3'd7;
   // Last bit position in a byte
   localparam logic [2:0] BIT_LAST = 3'd7;

   // Reading check outcome, first failing check wins
   typedef enum logic [2:0] {
      FAULT_NONE       = 3'd0,
      FAULT_FRAMING    = 3'd1,
      FAULT_NO_ACK     = 3'd2,
      FAULT_BYTE_COUNT = 3'd3,
      FAULT_CHECKSUM   = 3'd4
   } fault_type;

   // True when gap lies strictly inside (max(center - tol, 0), center + tol)
   function automatic logic in_window(input logic [TIME_W-1:0] gap,
                                      input logic [TIME_W-1:0] center,
                                      input logic [TIME_W-1:0] tol);
      logic [TIME_W-1:0] lo;
      logic [TIME_W:0]   hi;
      lo = (center > tol) ? (center - tol) : '0;
      hi = {1'b0, center} + {1'b0, tol};
      return (gap > lo) && ({1'b0, gap} < hi);
   endfunction

endpackage

### src/humidity_sensor_pulse_decoder.sv
// Top level of the single-wire humidity sensor pulse decoder.
// Depends on hspd_pkg for field widths, register indexes and fault codes.
//
// Usage:
//   req_*  : one word per falling edge of the sensor line; tdata carries the
//            captured 16-bit timer value, tuser flags the first edge of a
//            reading. Edges are classified as they arrive (acknowledge, one,
//            zero, else framing error) and bits are packed MSB first.
//   rsp_*  : one word per reading, given with the reading's last edge. tuser
//            holds frame_ok and the fault code, tdata the scaled humidity and
//            temperature (both zero on a failed reading).
//   csr_*  : register writes, always ready; write only while the block is idle.
// Throughput: one edge per cycle, unless held off as under Stall. Latency: the result
// word is valid in the cycle after the last edge is taken; all per-edge work (gap
// subtract, three window compares, bit shift, checksum add, scaling) sits between
// the input handshake and the result register.
// Stall: a waiting result does not block edges; only an edge that could close
// the next reading is held off until the waiting word is taken.
// Reset: registers return to their reset values, no reading is open and the
// result register is empty. Stored frame bytes are not cleared.
module humidity_sensor_pulse_decoder
   import hspd_pkg::*;
#(
   parameter int EDGES_PER_READING = 42,
   parameter int FRAME_BYTES       = 5
) (
   input  logic        clock,
   input  logic        reset,
   // Edge stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] edge_time
   input  logic        req_tuser,   // [0] frame_start
   // Reading results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [14:0] humidity_scaled, [29:15] temperature_scaled
   output logic [3:0]  rsp_tuser,   // [0] frame_ok, [3:1] fault_kind
   // Register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam logic [5:0] LAST_EDGE   = 6'(EDGES_PER_READING);
   localparam logic [5:0] CLOSE_EDGE  = 6'(EDGES_PER_READING - 1);
   localparam logic [2:0] BYTES_TOTAL = 3'(FRAME_BYTES);
   localparam logic [2:0] CHECK_IDX   = 3'(FRAME_BYTES - 1);

   // Configuration registers
   logic [TIME_W-1:0] ack_center_ff, one_center_ff, zero_center_ff, tolerance_ff;

   // Frame state
   logic [TIME_W-1:0] prev_edge_ff,  prev_edge_in;
   logic [5:0]        edge_count_ff, edge_count_in;
   logic [2:0]        bit_pos_ff,    bit_pos_in;
   logic [2:0]        byte_count_ff, byte_count_in;
   logic [BYTE_W-1:0] byte_shift_ff, byte_shift_in;
   logic [BYTE_W-1:0] data_sum_ff,   data_sum_in;
   logic [BYTE_W-1:0] check_byte_ff, check_byte_in;
   logic              ack_seen_ff,   ack_seen_in;
   logic              framing_ff,    framing_in;
   logic [BYTE_W-1:0] frame_bytes_ff [4];
   logic [BYTE_W-1:0] frame_bytes_in [4];

   // Result register
   logic              rsp_valid_ff;
   logic [31:0]       rsp_data_ff;
   logic [3:0]        rsp_user_ff;

   // Per-edge signals
   logic              req_fire;
   logic              res_fire;
   logic [TIME_W-1:0] gap;
   logic              ack_hit, one_hit, zero_hit;
   logic [BYTE_W-1:0] full_byte;
   fault_type         fault;
   logic [BYTE_W-1:0] sel_byte [4];
   logic [SCALE_W-1:0] humidity, temperature;

   assign csr_ready  = 1'b1;
   // Hold off only an edge that could close a reading while a result waits
   assign req_tready = !(rsp_valid_ff && !rsp_tready && edge_count_ff == CLOSE_EDGE);
   assign req_fire   = req_tvalid && req_tready;

   // Classify the gap
   assign gap      = req_tdata - prev_edge_ff;
   assign ack_hit  = in_window(gap, ack_center_ff, tolerance_ff);
   assign one_hit  = in_window(gap, one_center_ff, tolerance_ff);
   assign zero_hit = in_window(gap, zero_center_ff, tolerance_ff);

   // Current byte with the new bit placed MSB first
   always_comb begin
      full_byte = byte_shift_ff;
      full_byte[BIT_LAST - bit_pos_ff] = !ack_hit && one_hit;
   end

   // Next frame state
   always_comb begin
      prev_edge_in  = prev_edge_ff;
      edge_count_in = edge_count_ff;
      bit_pos_in    = bit_pos_ff;
      byte_count_in = byte_count_ff;
      byte_shift_in = byte_shift_ff;
      data_sum_in   = data_sum_ff;
      check_byte_in = check_byte_ff;
      ack_seen_in   = ack_seen_ff;
      framing_in    = framing_ff;
      frame_bytes_in = frame_bytes_ff;
      res_fire      = 1'b0;
      if (req_fire) begin
         priority if (req_tuser || edge_count_ff == '0) begin
            // open a new reading
            prev_edge_in  = req_tdata;
            edge_count_in = 6'd1;
            bit_pos_in    = '0;
            byte_count_in = '0;
            byte_shift_in = '0;
            data_sum_in   = '0;
            check_byte_in = '0;
            ack_seen_in   = 1'b0;
            framing_in    = 1'b0;
         end else if (edge_count_ff < LAST_EDGE) begin
            prev_edge_in  = req_tdata;
            edge_count_in = edge_count_ff + 6'd1;
            if (!framing_ff) begin
               priority if (ack_hit) begin
                  ack_seen_in = 1'b1;
               end else if (one_hit || zero_hit) begin
                  if (bit_pos_ff == BIT_LAST) begin
                     // byte complete: store, sum or take as checksum
                     if (!byte_count_ff[2]) begin
                        frame_bytes_in[byte_count_ff[1:0]] = full_byte;
                     end
                     if (byte_count_ff < CHECK_IDX) begin
                        data_sum_in = data_sum_ff + full_byte;
                     end else if (byte_count_ff == CHECK_IDX) begin
                        check_byte_in = full_byte;
                     end
                     if (byte_count_ff != BYTE_COUNT_MAX) begin
                        byte_count_in = byte_count_ff + 3'd1;
                     end
                     byte_shift_in = '0;
                     bit_pos_in    = '0;
                  end else begin
                     byte_shift_in = full_byte;
                     bit_pos_in    = bit_pos_ff + 3'd1;
                  end
               end else begin
                  framing_in = 1'b1;
               end
            end
            res_fire = (edge_count_in == LAST_EDGE);
         end else begin
            // reading closed: drop the edge until a new reading starts
            res_fire = 1'b0;
         end
      end
   end

   // Check the reading, first failing check wins
   always_comb begin
      priority if (framing_in)                   fault = FAULT_FRAMING;
      else if (!ack_seen_in)                     fault = FAULT_NO_ACK;
      else if (byte_count_in != BYTES_TOTAL)     fault = FAULT_BYTE_COUNT;
      else if (data_sum_in != check_byte_in)     fault = FAULT_CHECKSUM;
      else                                       fault = FAULT_NONE;
   end

   // Scale the readings; bytes past the frame length read as zero
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sel_byte[i] = (i < FRAME_BYTES) ? frame_bytes_in[i] : '0;
      end
      humidity    = SCALE_W'(sel_byte[0]) * SCALE_HUNDRED + SCALE_W'(sel_byte[1]);
      temperature = SCALE_W'(sel_byte[2]) * SCALE_HUNDRED
                  + SCALE_W'(sel_byte[3]) * SCALE_TEN;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ack_center_ff  <= ACK_CENTER_RST;
         one_center_ff  <= ONE_CENTER_RST;
         zero_center_ff <= ZERO_CENTER_RST;
         tolerance_ff   <= TOLERANCE_RST;
      end else if (csr_valid) begin
         if (csr_index == REG_ACK_CENTER)  ack_center_ff  <= csr_data;
         if (csr_index == REG_ONE_CENTER)  one_center_ff  <= csr_data;
         if (csr_index == REG_ZERO_CENTER) zero_center_ff <= csr_data;
         if (csr_index == REG_TOLERANCE)   tolerance_ff   <= csr_data;
      end
   end

   // Frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_edge_ff  <= '0;
         edge_count_ff <= '0;
         bit_pos_ff    <= '0;
         byte_count_ff <= '0;
         byte_shift_ff <= '0;
         data_sum_ff   <= '0;
         check_byte_ff <= '0;
         ack_seen_ff   <= 1'b0;
         framing_ff    <= 1'b0;
      end else begin
         prev_edge_ff  <= prev_edge_in;
         edge_count_ff <= edge_count_in;
         bit_pos_ff    <= bit_pos_in;
         byte_count_ff <= byte_count_in;
         byte_shift_ff <= byte_shift_in;
         data_sum_ff   <= data_sum_in;
         check_byte_ff <= check_byte_in;
         ack_seen_ff   <= ack_seen_in;
         framing_ff    <= framing_in;
      end
   end

   // Stored frame bytes, payload only
   always_ff @(posedge clock) begin
      frame_bytes_ff <= frame_bytes_in;
   end

   // Result register: load on a closing edge, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_fire) begin
         rsp_user_ff <= {fault, fault == FAULT_NONE};
         if (fault == FAULT_NONE) begin
            rsp_data_ff <= {2'b00, temperature, humidity};
         end else begin
            rsp_data_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A new result never lands on a word that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid_ff && !rsp_tready && res_fire))
      else $error("result overwrote a waiting word");

   // Edge counter never passes the reading length
   a_edge_bound: assert property (@(posedge clock) disable iff (reset)
      edge_count_ff <= LAST_EDGE)
      else $error("edge count beyond reading length");

   // frame_ok agrees with the fault code
   a_ok_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] == (rsp_tuser[3:1] == FAULT_NONE)))
      else $error("frame_ok disagrees with fault code");

   // A closing edge is followed in the next cycle by a valid result, zero data if failed
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      res_fire |=> rsp_tvalid && (rsp_tuser[0] || rsp_tdata == '0))
      else $error("failed reading carries data or result missing");

endmodule
